[hdl/arpc_pkg.sv]
// Shared types and constants for the ARP address cache.
// No dependencies; imported by arpc_table and arp_address_cache.
package arpc_pkg;

  // configuration register map
  localparam int REG_IDX_W = 1;
  localparam int CFG_W     = 48;
  localparam logic [REG_IDX_W-1:0] REG_OWN_IP  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_OWN_MAC = 1'd1;

  // request kinds
  localparam logic [1:0] KIND_UPDATE  = 2'd0;
  localparam logic [1:0] KIND_IP_LKP  = 2'd1;
  localparam logic [1:0] KIND_MAC_LKP = 2'd2;

  // result status codes
  localparam logic [2:0] ST_HIT         = 3'd0;
  localparam logic [2:0] ST_OWN         = 3'd1;
  localparam logic [2:0] ST_MISS        = 3'd2;
  localparam logic [2:0] ST_INSERTED    = 3'd3;
  localparam logic [2:0] ST_OVERWRITTEN = 3'd4;
  localparam logic [2:0] ST_PRESENT     = 3'd5;
  localparam logic [2:0] ST_FULL        = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] hw_addr;
    logic [31:0] net_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] found_mac;
    logic [31:0] found_ip;
  } out_item_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

[hdl/arpc_table.sv]
// Entry store of the ARP cache: one write port, one registered read port.
// Depends on arpc_pkg (entry_t).
module arpc_table
  import arpc_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/arp_address_cache.sv]
// ARP address cache top level: sequencer scanning the entry store with one compare unit.
// The scan reads the used entries in order and ends at the first match. One transaction at a
// time; the store read port delivers one entry per cycle.
// Synchronous reset (rst) clears the fill count, own addresses and handshake state, not entries.
// Depends on arpc_pkg and arpc_table.
module arp_address_cache
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;   // next entry to read
  logic [IDX_W-1:0] cmp_idx;               // entry whose data is on rd_entry
  logic             rd_pend;               // rd_entry holds a fresh read
  logic [CNT_W-1:0] used_count, used_count_next;
  logic [31:0]      own_ip;
  logic [47:0]      own_mac;
  in_item_t         req;                   // transaction being worked on
  out_item_t        res, res_next;         // output register

  logic             issue;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             mac_eq, ip_eq, hit;

  arpc_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_data  = res;

  // shared compare unit: one stored entry against the request key per cycle
  assign mac_eq = (rd_entry.mac == req.hw_addr);
  assign ip_eq  = (rd_entry.ip == req.net_addr);

  always_comb begin
    unique case (req.kind)
      KIND_UPDATE:  hit = rd_pend && (mac_eq || ip_eq);
      KIND_IP_LKP:  hit = rd_pend && ip_eq;
      KIND_MAC_LKP: hit = rd_pend && mac_eq;
      default:      hit = 1'b0;   // unknown kind scans through to a miss
    endcase
  end

  // state register and handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pend    <= 1'b0;
      used_count <= '0;
      rd_idx     <= '0;
    end else begin
      state      <= state_next;
      rd_pend    <= issue;
      used_count <= used_count_next;
      rd_idx     <= rd_idx_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res <= res_next;
    if (issue) begin
      cmp_idx <= rd_idx[IDX_W-1:0];
    end
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_IP:  own_ip  <= cfg_data[31:0];
        REG_OWN_MAC: own_mac <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // sequencer: issue one read a cycle, compare the returning entry, stop on first match
  always_comb begin
    state_next      = state;
    rd_idx_next     = rd_idx;
    used_count_next = used_count;
    res_next        = res;
    issue           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = cmp_idx;
    wr_entry        = '{mac: req.hw_addr, ip: req.net_addr};

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rd_idx_next = '0;
          state_next  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_next = S_DONE;
          res_next   = '{status: ST_HIT, found_mac: '0, found_ip: '0};
          unique case (req.kind)
            KIND_UPDATE: begin
              if (mac_eq && ip_eq) begin
                res_next.status = ST_PRESENT;
              end else begin
                // single-field match: overwrite that entry with the new pair
                res_next.status = ST_OVERWRITTEN;
                wr_en           = 1'b1;
              end
            end
            KIND_IP_LKP:  res_next.found_mac = rd_entry.mac;
            KIND_MAC_LKP: res_next.found_ip  = rd_entry.ip;
            default: ;
          endcase
        end else if (!rd_pend && (rd_idx >= used_count)) begin
          // scan exhausted with no match
          state_next = S_DONE;
          res_next   = '{status: ST_MISS, found_mac: '0, found_ip: '0};
          unique case (req.kind)
            KIND_UPDATE: begin
              if (used_count == CNT_W'(TABLE_DEPTH)) begin
                res_next.status = ST_FULL;
              end else begin
                res_next.status = ST_INSERTED;
                wr_en           = 1'b1;
                wr_addr         = used_count[IDX_W-1:0];
                used_count_next = CNT_W'(used_count + 1'b1);
              end
            end
            KIND_IP_LKP: begin
              if (req.net_addr == own_ip) begin
                res_next.status    = ST_OWN;
                res_next.found_mac = own_mac;
              end
            end
            default: ;
          endcase
        end else begin
          issue = (rd_idx < used_count);
          if (issue) begin
            rd_idx_next = CNT_W'(rd_idx + 1'b1);
          end
        end
      end

      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

[tb/arp_address_cache_checker.sv]
`timescale 1ns / 1ps
// Checker for arp_address_cache: watches the request, result and register ports,
// keeps its own copy of the address table and compares every result. Needs arpc_pkg.
module arp_address_cache_checker
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   results_seen
);

  logic [47:0] cached_mac [TABLE_DEPTH];
  logic [31:0] cached_ip  [TABLE_DEPTH];
  int          fill;
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  out_item_t   answers_due [$];

  // update: exact pair is left alone, a half match is replaced, else append or drop
  function automatic logic [2:0] record_pair(input logic [47:0] mac, input logic [31:0] ip);
    for (int i = 0; i < fill; i++) begin
      if (cached_mac[i] == mac && cached_ip[i] == ip)
        return ST_PRESENT;
      if (cached_mac[i] == mac || cached_ip[i] == ip) begin
        cached_mac[i] = mac;
        cached_ip[i]  = ip;
        return ST_OVERWRITTEN;
      end
    end
    if (fill >= TABLE_DEPTH)
      return ST_FULL;
    cached_mac[fill] = mac;
    cached_ip[fill]  = ip;
    fill++;
    return ST_INSERTED;
  endfunction

  function automatic out_item_t resolve(input in_item_t req);
    out_item_t ans;
    ans.status    = ST_MISS;
    ans.found_mac = '0;
    ans.found_ip  = '0;
    case (req.kind)
      KIND_UPDATE: ans.status = record_pair(req.hw_addr, req.net_addr);
      KIND_IP_LKP: begin
        for (int i = 0; i < fill; i++) begin
          if (cached_ip[i] == req.net_addr) begin
            ans.status    = ST_HIT;
            ans.found_mac = cached_mac[i];
            break;
          end
        end
        // a cached entry wins over the own address
        if (ans.status != ST_HIT && req.net_addr == own_ip) begin
          ans.status    = ST_OWN;
          ans.found_mac = own_mac;
        end
      end
      KIND_MAC_LKP: begin
        // own_mac is never consulted here
        for (int i = 0; i < fill; i++) begin
          if (cached_mac[i] == req.hw_addr) begin
            ans.status   = ST_HIT;
            ans.found_ip = cached_ip[i];
            break;
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t due;
    if (rst) begin
      fill    = 0;
      own_ip  = '0;
      own_mac = '0;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OWN_IP)
          own_ip = cfg_data[31:0];
        else if (cfg_index == REG_OWN_MAC)
          own_mac = cfg_data;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          $error("result with no transaction outstanding: status %0d mac %h ip %h",
                 out_data.status, out_data.found_mac, out_data.found_ip);
          mismatches++;
        end else begin
          due = answers_due.pop_front();
          if (out_data.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_data.status);
            mismatches++;
          end
          if (out_data.found_mac !== due.found_mac) begin
            $error("found_mac: expected %h, got %h", due.found_mac, out_data.found_mac);
            mismatches++;
          end
          if (out_data.found_ip !== due.found_ip) begin
            $error("found_ip: expected %h, got %h", due.found_ip, out_data.found_ip);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        answers_due.push_back(resolve(in_data));
    end
    outstanding = answers_due.size();
  end

endmodule

[tb/arp_address_cache_tb.sv]
`timescale 1ns / 1ps
// Top of the arp_address_cache testbench: clock, reset, request and register stimulus,
// result back-pressure and verdict. Needs arpc_pkg, arp_address_cache and the checker.
module arp_address_cache_tb;
  import arpc_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int POOL_SIZE     = 20;   // a little more than the table, so it overflows
  localparam int RANDOM_ITEMS  = 2000;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int CYCLE_LIMIT   = 400000;
  // the fourth request code has no meaning; the block must answer it as a miss
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_OWN_IP;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatches;
  int outstanding;
  int results_seen;

  // pacing, in percent of cycles spent idle
  int send_idle = 30;
  int recv_idle = 53;

  int cycle_count = 0;
  int kind_count [4];
  int reg_writes = 0;

  // address pools: random content, but reused so updates and lookups collide
  logic [47:0] mac_pool [POOL_SIZE];
  logic [31:0] ip_pool  [POOL_SIZE];
  logic [31:0] cur_own_ip;
  logic [47:0] cur_own_mac;

  arp_address_cache #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  arp_address_cache_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("arp_address_cache test failed");
      $finish;
    end
  end

  // result side: random stalls, changed on the falling edge only
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [47:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [47:0] pick_mac();
    if ($urandom_range(99) < 85)
      return mac_pool[$urandom_range(POOL_SIZE - 1)];
    return rand_mac();
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(99) < 85)
      return ip_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // one request transaction; called and returns on a falling edge.
  // valid is left high on return so back-to-back transactions need no toggle.
  task automatic send_req(input logic [1:0] k, input logic [47:0] mac, input logic [31:0] ip);
    in_item_t req;
    req.kind     = k;
    req.hw_addr  = mac;
    req.net_addr = ip;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    @(negedge clk);
    kind_count[k]++;
  endtask

  // let every outstanding result come back before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  // own_ip goes out with junk in the unused upper bits
  task automatic set_own(input logic [31:0] ip, input logic [47:0] mac);
    cur_own_ip  = ip;
    cur_own_mac = mac;
    write_reg(REG_OWN_IP, {16'($urandom), ip});
    write_reg(REG_OWN_MAC, mac);
  endtask

  // mostly pool-based traffic so that hits, overwrites and exact repeats are common
  task automatic random_req();
    int sel;
    int k;
    sel = $urandom_range(99);
    k   = $urandom_range(POOL_SIZE - 1);
    if (sel < 45) begin
      case ($urandom_range(3))
        0, 1: send_req(KIND_UPDATE, mac_pool[k], ip_pool[k]);          // consistent pair
        2:    send_req(KIND_UPDATE, mac_pool[k], pick_ip());           // rebinding
        default: send_req(KIND_UPDATE, pick_mac(), ip_pool[k]);
      endcase
    end else if (sel < 70) begin
      send_req(KIND_IP_LKP, rand_mac(), ($urandom_range(9) == 0) ? cur_own_ip : pick_ip());
    end else if (sel < 92) begin
      send_req(KIND_MAC_LKP, ($urandom_range(9) == 0) ? cur_own_mac : pick_mac(), $urandom);
    end else begin
      send_req(KIND_UNUSED, rand_mac(), $urandom);
    end
  endtask

  initial begin : stimulus
    logic [47:0] fresh_mac;
    logic [31:0] fresh_ip;

    for (int i = 0; i < POOL_SIZE; i++) begin
      mac_pool[i] = rand_mac();
      ip_pool[i]  = $urandom;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_own($urandom, rand_mac());

    // directed: empty table, own addresses, extremes, then fill to overflow
    send_req(KIND_IP_LKP, '0, cur_own_ip);                 // own IP with no entry
    send_req(KIND_MAC_LKP, cur_own_mac, '0);               // own MAC is not answered
    send_req(KIND_UNUSED, '1, '1);                         // meaningless request code
    send_req(KIND_UPDATE, '0, '0);                         // inserted, all-zero pair
    send_req(KIND_UPDATE, '1, '1);                         // inserted, all-ones pair
    send_req(KIND_UPDATE, '1, '1);                         // already present
    send_req(KIND_UPDATE, '1, ip_pool[0]);                 // MAC match, overwritten
    send_req(KIND_UPDATE, 48'h1, '0);                      // IP match, overwritten
    send_req(KIND_UPDATE, mac_pool[2], cur_own_ip);        // own IP cached
    send_req(KIND_IP_LKP, '0, cur_own_ip);                 // cache wins over own IP
    send_req(KIND_MAC_LKP, mac_pool[2], '0);               // MAC hit
    send_req(KIND_IP_LKP, '1, '0);                         // IP hit on first entry
    for (int i = 3; i < TABLE_DEPTH; i++)
      send_req(KIND_UPDATE, mac_pool[i], ip_pool[i]);      // fills the table
    fresh_mac = rand_mac();
    fresh_ip  = $urandom;
    send_req(KIND_UPDATE, fresh_mac, fresh_ip);            // table full, dropped

    // random phases with different pacing and register settings
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle = 30;
          recv_idle = 53;
          set_own(ip_pool[$urandom_range(POOL_SIZE - 1)], rand_mac());
        end
        1: begin
          send_idle = 53;
          recv_idle = 30;
          set_own('1, '1);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          set_own('0, '0);
        end
      endcase
      repeat (RANDOM_ITEMS / 3) random_req();
    end

    drain();
    $display("Covered %0d updates, %0d IP lookups, %0d MAC lookups, %0d unused codes",
             kind_count[KIND_UPDATE], kind_count[KIND_IP_LKP], kind_count[KIND_MAC_LKP],
             kind_count[KIND_UNUSED]);
    $display("over three pacing phases and %0d register writes; %0d results checked",
             reg_writes, results_seen);
    if (mismatches == 0)
      $display("arp_address_cache test passed");
    else
      $display("arp_address_cache test failed");
    $finish;
  end

endmodule

[files.f]
hdl/arpc_pkg.sv
hdl/arpc_table.sv
hdl/arp_address_cache.sv
tb/arp_address_cache_checker.sv
tb/arp_address_cache_tb.sv
